// File: rtl/psdb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psdb_pkg: shared types and tables for the pixel shade/dither/blend block
// Configuration record, register map, blend codes, texel expansion and
// ordered dither tables.
// ----------------------------------------------------------------------------
package psdb_pkg;

  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned NUM_CH   = 3;
  localparam logic [15:0] MASK_BIT = 16'h8000;

  typedef enum logic [2:0] {
    REG_MODULATE_ENABLE   = 3'd0,
    REG_DITHER_ENABLE     = 3'd1,
    REG_BLEND_ENABLE      = 3'd2,
    REG_BLEND_MODE        = 3'd3,
    REG_SET_MASK_BIT      = 3'd4,
    REG_MASK_CHECK_ENABLE = 3'd5,
    REG_SPARE6            = 3'd6,
    REG_SPARE7            = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    BLEND_AVG     = 2'd0,
    BLEND_ADD     = 2'd1,
    BLEND_SUB     = 2'd2,
    BLEND_QUARTER = 2'd3
  } blend_mode_t;

  typedef struct packed {
    logic        modulate_enable;
    logic        dither_enable;
    logic        blend_enable;
    blend_mode_t blend_mode;
    logic        set_mask_bit;
    logic        mask_check_enable;
  } cfg_t;

  // 5-bit texel channel expanded to 8 bits: floor(t * 255 / 31)
  localparam logic [7:0] EXPAND5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  // ordered 4x4 dither offsets, indexed by {y_phase, x_phase}
  localparam logic signed [3:0] DITHER [16] = '{
    -4'sd4,  4'sd0, -4'sd3,  4'sd1,
     4'sd2, -4'sd2,  4'sd3, -4'sd1,
    -4'sd3,  4'sd1, -4'sd4,  4'sd0,
     4'sd3, -4'sd1,  4'sd2, -4'sd2
  };

endpackage
`default_nettype wire

// File: rtl/psdb_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psdb_regs: configuration register file
// APB-style slave, zero wait states, six control registers at 4*index.
// ----------------------------------------------------------------------------
module psdb_regs import psdb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_MODULATE_ENABLE:   cfg.modulate_enable   <= pwdata[0];
        REG_DITHER_ENABLE:     cfg.dither_enable     <= pwdata[0];
        REG_BLEND_ENABLE:      cfg.blend_enable      <= pwdata[0];
        REG_BLEND_MODE:        cfg.blend_mode        <= blend_mode_t'(pwdata[1:0]);
        REG_SET_MASK_BIT:      cfg.set_mask_bit      <= pwdata[0];
        REG_MASK_CHECK_ENABLE: cfg.mask_check_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MODULATE_ENABLE:   prdata[0]   = cfg.modulate_enable;
      REG_DITHER_ENABLE:     prdata[0]   = cfg.dither_enable;
      REG_BLEND_ENABLE:      prdata[0]   = cfg.blend_enable;
      REG_BLEND_MODE:        prdata[1:0] = cfg.blend_mode;
      REG_SET_MASK_BIT:      prdata[0]   = cfg.set_mask_bit;
      REG_MASK_CHECK_ENABLE: prdata[0]   = cfg.mask_check_enable;
      default:               prdata      = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/pixel_shade_dither_blend_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_shade_dither_blend_top: per-pixel shade, dither and blend back end
// Shades a pixel (texel modulate or expand), adds ordered dither, truncates
// to 5 bits per channel, blends with the frame-buffer pixel and sets mask.
//
//   channel  | ports                                    | handshake
//   ---------+------------------------------------------+--------------------
//   config   | psel penable pwrite paddr pwdata prdata  | APB, pready tied 1
//   item in  | color_r/g/b textured texel back_pixel    | start & !busy
//            | x_phase y_phase                          |
//   item out | write_enable pixel_out                   | done, one cycle
//
// One item per clock; each result is registered in stages 1, 2 and 3.
// Stage 1 does the texel multiply/expand, stage 2 dither and clamp, stage 3
// blend and packing into the output register. busy stays low: the pipeline
// never stalls because the receiver takes every result.
// rst (synchronous) clears the registers and the valid bits; data registers
// are not reset.
// ----------------------------------------------------------------------------
module pixel_shade_dither_blend_top import psdb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // item in
  input  logic              start,
  output logic              busy,
  input  logic [7:0]        color_r,
  input  logic [7:0]        color_g,
  input  logic [7:0]        color_b,
  input  logic              textured,
  input  logic [15:0]       texel,
  input  logic [15:0]       back_pixel,
  input  logic [1:0]        x_phase,
  input  logic [1:0]        y_phase,
  // item out
  output logic              done,
  output logic              write_enable,
  output logic [15:0]       pixel_out
);

  cfg_t cfg;

  psdb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the pipeline takes an item every cycle
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // --------------------------------------------------------------------------
  // Stage 1: shade. Modulate (c*t)>>4 with saturation, or expand the texel.
  // --------------------------------------------------------------------------
  logic [7:0]  col_in [NUM_CH];
  logic [4:0]  tex5   [NUM_CH];
  logic [7:0]  shade  [NUM_CH];
  logic [12:0] prod   [NUM_CH];
  logic        kill_in;
  logic        tmask_in;
  logic        blend_in;

  assign col_in[0] = color_r;
  assign col_in[1] = color_g;
  assign col_in[2] = color_b;

  always_comb begin
    // untextured pixels ignore the texel entirely
    tmask_in = textured & texel[15];
    kill_in  = (cfg.mask_check_enable & back_pixel[15]) | (textured & (texel == '0));
    blend_in = cfg.blend_enable & (~textured | tmask_in);
    for (int i = 0; i < NUM_CH; i++) begin
      tex5[i] = texel[5*i +: 5];
      prod[i] = 13'(col_in[i]) * 13'(tex5[i]);
      if (!textured) begin
        shade[i] = col_in[i];
      end else if (cfg.modulate_enable) begin
        shade[i] = prod[i][12] ? 8'hFF : prod[i][11:4];
      end else begin
        shade[i] = EXPAND5[tex5[i]];
      end
    end
  end

  logic              s1_valid;
  logic [7:0]        s1_col [NUM_CH];
  logic              s1_kill;
  logic              s1_tmask;
  logic              s1_blend;
  logic [14:0]       s1_back;
  logic signed [3:0] s1_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= shade;
      s1_kill  <= kill_in;
      s1_tmask <= tmask_in;
      s1_blend <= blend_in;
      s1_back  <= back_pixel[14:0];
      s1_off   <= DITHER[{y_phase, x_phase}];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: add the dither offset, clamp to 0..255, drop to 5 bits.
  // --------------------------------------------------------------------------
  logic signed [9:0] dsum  [NUM_CH];
  logic [4:0]        front [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      dsum[i] = $signed({2'b00, s1_col[i]}) + 10'(s1_off);
      if (!cfg.dither_enable) begin
        front[i] = s1_col[i][7:3];
      end else if (dsum[i] < 0) begin
        front[i] = 5'd0;
      end else if (dsum[i] > 10'sd255) begin
        front[i] = 5'h1F;
      end else begin
        front[i] = dsum[i][7:3];
      end
    end
  end

  logic        s2_valid;
  logic [4:0]  s2_front [NUM_CH];
  logic        s2_kill;
  logic        s2_tmask;
  logic        s2_blend;
  logic [14:0] s2_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_front <= front;
      s2_kill  <= s1_kill;
      s2_tmask <= s1_tmask;
      s2_blend <= s1_blend;
      s2_back  <= s1_back;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: blend with the back pixel, pack 1555, apply mask bit.
  // --------------------------------------------------------------------------
  logic [4:0]  bch   [NUM_CH];
  logic [4:0]  mixed [NUM_CH];
  logic [5:0]  sum_f [NUM_CH];
  logic [5:0]  sum_q [NUM_CH];
  logic [15:0] pix;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      bch[i]   = s2_back[5*i +: 5];
      sum_f[i] = 6'(bch[i]) + 6'(s2_front[i]);
      sum_q[i] = 6'(bch[i]) + 6'(s2_front[i][4:2]);
      mixed[i] = s2_front[i];
      if (s2_blend) begin
        case (cfg.blend_mode)
          BLEND_AVG:     mixed[i] = sum_f[i][5:1];
          BLEND_ADD:     mixed[i] = sum_f[i][5] ? 5'h1F : sum_f[i][4:0];
          BLEND_SUB:     mixed[i] = (bch[i] > s2_front[i]) ? bch[i] - s2_front[i] : 5'd0;
          BLEND_QUARTER: mixed[i] = sum_q[i][5] ? 5'h1F : sum_q[i][4:0];
          default:       mixed[i] = s2_front[i];
        endcase
      end
    end
    pix = {s2_tmask | cfg.set_mask_bit, mixed[2], mixed[1], mixed[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
  end

  // suppressed writes report a zero pixel
  always_ff @(posedge clk) begin
    if (s2_valid) begin
      write_enable <= ~s2_kill;
      pixel_out    <= s2_kill ? 16'h0000 : pix;
    end
  end

endmodule
`default_nettype wire

// File: sim/pixel_shade_dither_blend_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_shade_dither_blend_top_tb: self-checking bench for the pixel back end
// Drives pixels through the start/busy port and programs the six control
// registers over APB while the block is idle. Every pixel taken in is run
// through a local shading/dither/blend predictor, and each done strobe is
// checked field by field against the oldest prediction. A directed set
// covers clamps, saturation, suppressed writes and all blend modes. Random
// phases follow, each under its own register setting and pacing.
// ----------------------------------------------------------------------------
module pixel_shade_dither_blend_top_tb;
  import psdb_pkg::*;

  localparam int DRAIN_CYCLES   = 8;     // pipeline is three deep, keep margin
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 125;
  localparam int NUM_PHASES     = 14;

  // ordered dither offsets, row = y phase, column = x phase
  localparam int DITHER_OFS [16] = '{-4,  0, -3,  1,
                                      2, -2,  3, -1,
                                     -3,  1, -4,  0,
                                      3, -1,  2, -2};

  typedef struct packed {
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        textured;
    logic [15:0] texel;
    logic [15:0] back;
    logic [1:0]  xp;
    logic [1:0]  yp;
  } pixel_item_t;

  typedef struct packed {
    logic        write_enable;
    logic [15:0] pixel;
  } pixel_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              start;
  logic              busy;
  logic [7:0]        color_r;
  logic [7:0]        color_g;
  logic [7:0]        color_b;
  logic              textured;
  logic [15:0]       texel;
  logic [15:0]       back_pixel;
  logic [1:0]        x_phase;
  logic [1:0]        y_phase;
  logic              done;
  logic              write_enable;
  logic [15:0]       pixel_out;

  cfg_t          shade_cfg;         // register image seen by the predictor
  pixel_result_t expected_pixels[$];
  int            error_count;
  int            stall_cycles;

  pixel_shade_dither_blend_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: shade, dither, truncate to 5 bits, blend, then set mask.
  // --------------------------------------------------------------------------
  function automatic pixel_result_t shade_pixel(pixel_item_t it, cfg_t c);
    pixel_result_t res;
    logic [15:0]   tx;
    logic [7:0]    chan [3];
    int            v;
    int            f;
    int            bk;
    int            t5;
    int            ofs;
    res.write_enable = 1'b0;
    res.pixel        = 16'h0000;
    // untextured pixels ignore the texel entirely
    tx = it.textured ? it.texel : 16'h0000;
    // suppressed write: masked back pixel, or a fully transparent texel
    if ((c.mask_check_enable && it.back[15]) || (it.textured && tx == 16'h0000))
      return res;
    chan[0] = it.r;
    chan[1] = it.g;
    chan[2] = it.b;
    ofs = DITHER_OFS[{it.yp, it.xp}];
    for (int ch = 0; ch < NUM_CH; ch++) begin
      v  = int'(chan[ch]);
      t5 = int'(tx[5*ch +: 5]);
      bk = int'(it.back[5*ch +: 5]);
      if (it.textured) begin
        if (c.modulate_enable) begin
          v = (v * t5) >> 4;
          if (v > 255) v = 255;
        end else begin
          v = (t5 * 255) / 31;
        end
      end
      if (c.dither_enable) begin
        v = v + ofs;
        if (v < 0)   v = 0;
        if (v > 255) v = 255;
      end
      f = v >> 3;
      // textured pixels only blend when the texel carries its mask bit
      if (c.blend_enable && (!it.textured || tx[15])) begin
        case (c.blend_mode)
          BLEND_AVG:     f = (bk + f) >> 1;
          BLEND_ADD:     f = (bk + f > 31) ? 31 : bk + f;
          BLEND_SUB:     f = (bk > f) ? bk - f : 0;
          BLEND_QUARTER: f = (bk + (f >> 2) > 31) ? 31 : bk + (f >> 2);
          default:       f = f;
        endcase
      end
      res.pixel[5*ch +: 5] = f[4:0];
    end
    res.pixel[15]    = tx[15] | c.set_mask_bit;
    res.write_enable = 1'b1;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: track register writes, predict accepted items, check results,
  // and run the watchdog. Sample everything at the rising edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_item_t   seen;
    pixel_result_t want;
    logic          progress;
    if (rst) begin
      shade_cfg = '0;
      expected_pixels.delete();
      stall_cycles = 0;
    end else begin
      progress = 1'b0;
      if (psel && penable && pwrite && pready) begin
        progress = 1'b1;
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_MODULATE_ENABLE:   shade_cfg.modulate_enable   = pwdata[0];
          REG_DITHER_ENABLE:     shade_cfg.dither_enable     = pwdata[0];
          REG_BLEND_ENABLE:      shade_cfg.blend_enable      = pwdata[0];
          REG_BLEND_MODE:        shade_cfg.blend_mode        = blend_mode_t'(pwdata[1:0]);
          REG_SET_MASK_BIT:      shade_cfg.set_mask_bit      = pwdata[0];
          REG_MASK_CHECK_ENABLE: shade_cfg.mask_check_enable = pwdata[0];
          default: ;
        endcase
      end
      // queue the prediction first so a result in the same cycle still matches
      if (start && !busy) begin
        progress = 1'b1;
        seen = '{color_r, color_g, color_b, textured, texel, back_pixel,
                 x_phase, y_phase};
        expected_pixels.push_back(shade_pixel(seen, shade_cfg));
      end
      if (done) begin
        progress = 1'b1;
        if (expected_pixels.size() == 0) begin
          $error("unexpected result: write_enable %0b pixel_out %h",
                 write_enable, pixel_out);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (write_enable !== want.write_enable) begin
            $error("write_enable mismatch: expected %0b, got %0b",
                   want.write_enable, write_enable);
            error_count++;
          end
          if (pixel_out !== want.pixel) begin
            $error("pixel_out mismatch: expected %h, got %h", want.pixel, pixel_out);
            error_count++;
          end
        end
      end
      stall_cycles = progress ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("pixel_shade_dither_blend_top test failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared driver tasks. Inputs change on the falling edge.
  // --------------------------------------------------------------------------
  task automatic apb_access(input bit wr, input reg_idx_t idx, input logic [31:0] wdata);
    logic [31:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr) begin
      case (idx)
        REG_MODULATE_ENABLE:   want = 32'(shade_cfg.modulate_enable);
        REG_DITHER_ENABLE:     want = 32'(shade_cfg.dither_enable);
        REG_BLEND_ENABLE:      want = 32'(shade_cfg.blend_enable);
        REG_BLEND_MODE:        want = 32'(shade_cfg.blend_mode);
        REG_SET_MASK_BIT:      want = 32'(shade_cfg.set_mask_bit);
        REG_MASK_CHECK_ENABLE: want = 32'(shade_cfg.mask_check_enable);
        default:               want = 32'h0;
      endcase
      if (prdata !== want) begin
        $error("prdata mismatch at register %s: expected %h, got %h",
               idx.name(), want, prdata);
        error_count++;
      end
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // drop start, let every result come back, then let the pipe drain
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // program all six registers; junk in the upper bits must be dropped
  task automatic set_config(input cfg_t c);
    wait_idle();
    apb_access(1'b1, REG_MODULATE_ENABLE,   ($urandom() << 2) | 32'(c.modulate_enable));
    apb_access(1'b1, REG_DITHER_ENABLE,     ($urandom() << 2) | 32'(c.dither_enable));
    apb_access(1'b1, REG_BLEND_ENABLE,      ($urandom() << 2) | 32'(c.blend_enable));
    apb_access(1'b1, REG_BLEND_MODE,        ($urandom() << 2) | 32'(c.blend_mode));
    apb_access(1'b1, REG_SET_MASK_BIT,      ($urandom() << 2) | 32'(c.set_mask_bit));
    apb_access(1'b1, REG_MASK_CHECK_ENABLE, ($urandom() << 2) | 32'(c.mask_check_enable));
  endtask

  task automatic read_all_regs();
    for (int i = 0; i <= int'(REG_MASK_CHECK_ENABLE); i++)
      apb_access(1'b0, reg_idx_t'(i), 32'h0);
  endtask

  // present one item and hold it until the block takes it
  task automatic send_pixel(input pixel_item_t it);
    @(negedge clk);
    start      <= 1'b1;
    color_r    <= it.r;
    color_g    <= it.g;
    color_b    <= it.b;
    textured   <= it.textured;
    texel      <= it.texel;
    back_pixel <= it.back;
    x_phase    <= it.xp;
    y_phase    <= it.yp;
    do @(posedge clk); while (busy);
  endtask

  // idle the sender for a random number of cycles, pct percent per cycle
  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  function automatic pixel_item_t mk_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic tex, logic [15:0] tx, logic [15:0] bk,
                                           logic [1:0] xp, logic [1:0] yp);
    return '{r, g, b, tex, tx, bk, xp, yp};
  endfunction

  // bias colors to the rails and texels to the special values now and then
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic pixel_item_t rand_pixel();
    pixel_item_t it;
    it.r        = rand_chan();
    it.g        = rand_chan();
    it.b        = rand_chan();
    it.textured = 1'($urandom_range(1));
    case ($urandom_range(9))
      0:       it.texel = 16'h0000;
      1:       it.texel = 16'h8000;
      2:       it.texel = 16'hFFFF;
      default: it.texel = 16'($urandom());
    endcase
    it.back = 16'($urandom());
    it.xp   = 2'($urandom());
    it.yp   = 2'($urandom());
    return it;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.modulate_enable   = 1'($urandom_range(1));
    c.dither_enable     = 1'($urandom_range(1));
    c.blend_enable      = 1'($urandom_range(1));
    c.blend_mode        = blend_mode_t'($urandom_range(3));
    c.set_mask_bit      = 1'($urandom_range(1));
    c.mask_check_enable = 1'($urandom_range(1));
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // all registers clear after reset: texels pass through expanded, no extras
  task automatic test_reset_defaults();
    read_all_regs();
    send_pixel(mk_pixel(8'h12, 8'h34, 8'h56, 1'b0, 16'hFFFF, 16'hFFFF, 2'd0, 2'd0));
    send_pixel(mk_pixel(8'hFF, 8'h00, 8'h80, 1'b1, 16'h7FFF, 16'h8000, 2'd3, 2'd3));
    send_pixel(mk_pixel(8'h00, 8'hFF, 8'h00, 1'b1, 16'h8421, 16'h0000, 2'd1, 2'd2));
  endtask

  // write and read back each register at both ends, and touch a spare slot
  task automatic test_registers();
    set_config('{1'b1, 1'b1, 1'b1, BLEND_QUARTER, 1'b1, 1'b1});
    read_all_regs();
    apb_access(1'b1, REG_SPARE6, 32'hFFFF_FFFF);
    read_all_regs();
    set_config('{1'b0, 1'b0, 1'b0, BLEND_AVG, 1'b0, 1'b0});
    read_all_regs();
  endtask

  // clamps, saturation, suppressed writes, mask handling, every blend mode
  task automatic test_directed();
    // modulate + dither + mask check, no blend
    set_config('{1'b1, 1'b1, 1'b0, BLEND_AVG, 1'b0, 1'b1});
    // dither -4 on black clamps at zero, +3 on white clamps at 255
    send_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 16'h0000, 2'd0, 2'd0));
    send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 16'h0000, 16'h0000, 2'd2, 2'd1));
    // modulate saturates at 255
    send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 16'h7FFF, 16'h0000, 2'd1, 2'd3));
    // zero texel drops a textured write but not an untextured one
    send_pixel(mk_pixel(8'h80, 8'h40, 8'h20, 1'b1, 16'h0000, 16'h0000, 2'd0, 2'd1));
    send_pixel(mk_pixel(8'h80, 8'h40, 8'h20, 1'b0, 16'h0000, 16'h0000, 2'd0, 2'd1));
    // mask check drops a write onto a masked back pixel
    send_pixel(mk_pixel(8'h80, 8'h40, 8'h20, 1'b0, 16'h0000, 16'h8000, 2'd3, 2'd0));
    // texel with only the mask bit is not transparent
    send_pixel(mk_pixel(8'hAA, 8'h55, 8'hFF, 1'b1, 16'h8000, 16'h0000, 2'd1, 2'd1));

    // texel expand, blend on, force mask; cycle through every blend mode
    for (int m = 0; m < 4; m++) begin
      set_config('{1'b0, 1'b0, 1'b1, blend_mode_t'(m), 1'b1, 1'b0});
      send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 16'h0000, 16'h7FFF, 2'd0, 2'd0));
      send_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 1'b1, 16'hC108, 16'h294A, 2'd2, 2'd2));
    end
    // blend gate closed: textured pixel without texel mask bit
    send_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 1'b1, 16'h4108, 16'h7FFF, 2'd1, 2'd0));
    // mask check off: a masked back pixel is still written
    send_pixel(mk_pixel(8'h10, 8'h20, 8'h30, 1'b0, 16'hFFFF, 16'hFFFF, 2'd3, 2'd2));
  endtask

  // random pixels in phases; each phase gets a setting and a pacing
  task automatic test_random_traffic();
    int   idle_mix [4] = '{0, 77, 0, 6};
    cfg_t c;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0)      c = '0;
      else if (ph == 1) c = '{1'b1, 1'b1, 1'b1, BLEND_QUARTER, 1'b1, 1'b1};
      else              c = rand_cfg();
      set_config(c);
      repeat (PHASE_ITEMS) begin
        idle_gap(idle_mix[ph % 4]);
        send_pixel(rand_pixel());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    error_count = 0;
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    start       = 1'b0;
    color_r     = 8'h00;
    color_g     = 8'h00;
    color_b     = 8'h00;
    textured    = 1'b0;
    texel       = 16'h0000;
    back_pixel  = 16'h0000;
    x_phase     = 2'd0;
    y_phase     = 2'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_registers();
    test_directed();
    test_random_traffic();
    wait_idle();

    if (error_count == 0)
      $display("pixel_shade_dither_blend_top test passed");
    else
      $display("pixel_shade_dither_blend_top test failed");
    $finish;
  end

endmodule
`default_nettype wire
